>>> src/cbp_pkg.sv
// Shared types and constants for the correlating branch predictor.
// No dependencies; the other files that use it refer to it by scoped names.
package cbp_pkg;

   localparam int ADDR_W  = 64;
   localparam int COUNT_W = 32;
   localparam int HIST_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTER_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PC_BITS      = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RESET_HISTORY_BITS = 4'd0;
   localparam logic [CSR_DATA_W-1:0] RESET_COUNTER_BITS = 4'd1;
   localparam logic [CSR_DATA_W-1:0] RESET_PC_BITS      = 4'd0;

   typedef struct packed {
      logic step;
      logic taken;
      logic right;
   } stat_step_type;

endpackage

>>> src/cbp_if.sv
// Beat channels of the branch predictor: resolved branch in, prediction report out.
// Depends on cbp_pkg for field widths.
interface cbp_req_if;
   logic                       valid;
   logic                       ready;
   logic [cbp_pkg::ADDR_W-1:0] branch_address;
   logic                       branch_taken;

   modport source (output valid, branch_address, branch_taken, input ready);
   modport sink   (input valid, branch_address, branch_taken, output ready);
endinterface

interface cbp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        predicted_taken;
   logic                        prediction_correct;
   logic [cbp_pkg::COUNT_W-1:0] branches_seen;
   logic [cbp_pkg::COUNT_W-1:0] taken_seen;
   logic [cbp_pkg::COUNT_W-1:0] correct_seen;

   modport source (output valid, predicted_taken, prediction_correct, branches_seen,
                   taken_seen, correct_seen, input ready);
   modport sink   (input valid, predicted_taken, prediction_correct, branches_seen,
                   taken_seen, correct_seen, output ready);
endinterface

>>> src/cbp_table.sv
// Counter table: one-port-write, one-port-read synchronous memory with a post-reset clear sweep.
// Standalone; used by correlating_branch_predictor_core.
module cbp_table #(
   parameter int INDEX_BITS = 12,
   parameter int CTR_W      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [INDEX_BITS-1:0] rd_idx,
   output logic [CTR_W-1:0]      rd_data,
   input  logic                  wr_en,
   input  logic [INDEX_BITS-1:0] wr_idx,
   input  logic [CTR_W-1:0]      wr_data,
   output logic                  busy
);

   localparam int DEPTH = 1 << INDEX_BITS;

   logic [CTR_W-1:0]      mem [DEPTH];
   logic [CTR_W-1:0]      rd_data_ff;
   logic                  clr_busy_ff, clr_busy_in;
   logic [INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;

   always_comb begin
      clr_idx_in  = clr_idx_ff + 1'b1;
      clr_busy_in = clr_busy_ff && (clr_idx_ff != {INDEX_BITS{1'b1}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule

>>> src/cbp_stats.sv
// Saturating running counts of branches, taken branches and correct predictions.
// Depends on cbp_pkg for the step struct and count width.
module cbp_stats (
   input  logic                        clock,
   input  logic                        reset,
   input  cbp_pkg::stat_step_type      step,
   output logic [cbp_pkg::COUNT_W-1:0] branches,
   output logic [cbp_pkg::COUNT_W-1:0] takens,
   output logic [cbp_pkg::COUNT_W-1:0] corrects
);

   localparam logic [cbp_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   logic [cbp_pkg::COUNT_W-1:0] branch_ff, branch_in;
   logic [cbp_pkg::COUNT_W-1:0] taken_ff, taken_in;
   logic [cbp_pkg::COUNT_W-1:0] correct_ff, correct_in;

   always_comb begin
      branch_in  = branch_ff;
      taken_in   = taken_ff;
      correct_in = correct_ff;
      if (step.step) begin
         if (branch_ff != COUNT_MAX) begin
            branch_in = branch_ff + 1'b1;
         end
         if (step.taken && taken_ff != COUNT_MAX) begin
            taken_in = taken_ff + 1'b1;
         end
         if (step.right && correct_ff != COUNT_MAX) begin
            correct_in = correct_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         branch_ff  <= '0;
         taken_ff   <= '0;
         correct_ff <= '0;
      end else begin
         branch_ff  <= branch_in;
         taken_ff   <= taken_in;
         correct_ff <= correct_in;
      end
   end

   assign branches = branch_ff;
   assign takens   = taken_ff;
   assign corrects = correct_ff;

endmodule

>>> src/correlating_branch_predictor_core.sv
// Top level of the gselect correlating branch predictor.
// Depends on cbp_pkg, cbp_if, cbp_table and cbp_stats.
//
//  channel  | direction | handshake        | payload
//  req_bus  | in        | valid/ready      | branch_address, branch_taken
//  rsp_bus  | out       | valid/ready      | prediction, correctness, three counts
//  csr_*    | in        | csr_we, no ready | csr_index, csr_wdata
//
// One beat per cycle while not stalled: table read at accept, counter update and write-back in the update stage.
// A write-back to the entry read at the same edge is forwarded into the update.
// After reset req_bus.ready is held low while the table clear sweep runs.
// A stalled response holds the update stage, which in turn holds req_bus.ready low.
module correlating_branch_predictor_core #(
   parameter int INDEX_BITS       = 12,
   parameter int MAX_COUNTER_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [cbp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cbp_pkg::CSR_DATA_W-1:0] csr_wdata,
   cbp_req_if.sink                        req_bus,
   cbp_rsp_if.source                      rsp_bus
);

   localparam int CTR_W = MAX_COUNTER_BITS;
   localparam int CB_W  = 5;

   logic [cbp_pkg::CSR_DATA_W-1:0] hist_bits_ff, ctr_bits_ff, pc_bits_ff;
   logic [cbp_pkg::HIST_W-1:0]     hist_ff, hist_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [INDEX_BITS-1:0] s1_idx_ff;
   logic                  s1_taken_ff;
   logic                  s1_fwd_ff, s1_fwd_in;
   logic [CTR_W-1:0]      s1_fwd_data_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic pred_ff, right_ff;

   logic                  accept, s1_go, tbl_busy;
   logic [31:0]           hist_mask, pc_mask, idx_full;
   logic [INDEX_BITS-1:0] idx_in;
   logic [CTR_W-1:0]      rd_data, ctr, ctr_new, ctr_top, ctr_half;
   logic [CB_W-1:0]       cb;
   logic                  pred, right;
   cbp_pkg::stat_step_type stat_step;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_bits_ff <= cbp_pkg::RESET_HISTORY_BITS;
         ctr_bits_ff  <= cbp_pkg::RESET_COUNTER_BITS;
         pc_bits_ff   <= cbp_pkg::RESET_PC_BITS;
      end else if (csr_we) begin
         case (csr_index)
            cbp_pkg::CSR_HISTORY_BITS: hist_bits_ff <= csr_wdata;
            cbp_pkg::CSR_COUNTER_BITS: ctr_bits_ff  <= csr_wdata;
            cbp_pkg::CSR_PC_BITS:      pc_bits_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // index formation
   always_comb begin
      hist_mask = (32'd1 << hist_bits_ff) - 32'd1;
      pc_mask   = (32'd1 << pc_bits_ff) - 32'd1;
      idx_full  = (({16'd0, hist_ff} & hist_mask) << pc_bits_ff)
                | (req_bus.branch_address[31:0] & pc_mask);
      idx_in    = idx_full[INDEX_BITS-1:0];
   end

   assign s1_go         = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !tbl_busy && (!s1_valid_ff || s1_go);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      hist_in     = accept ? {hist_ff[cbp_pkg::HIST_W-2:0], req_bus.branch_taken} : hist_ff;
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s1_fwd_in   = s1_go && (s1_idx_ff == idx_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         hist_ff     <= hist_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff      <= idx_in;
         s1_taken_ff    <= req_bus.branch_taken;
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= ctr_new;
      end
   end

   // counter update
   always_comb begin
      if (ctr_bits_ff == '0) begin
         cb = CB_W'(1);
      end else if ({1'b0, ctr_bits_ff} > CB_W'(MAX_COUNTER_BITS)) begin
         cb = CB_W'(MAX_COUNTER_BITS);
      end else begin
         cb = {1'b0, ctr_bits_ff};
      end
      ctr_top  = {CTR_W{1'b1}} >> (CB_W'(CTR_W) - cb);
      ctr_half = CTR_W'(1) << (cb - CB_W'(1));
      ctr      = s1_fwd_ff ? s1_fwd_data_ff : rd_data;
      pred     = ctr >= ctr_half;
      right    = pred == s1_taken_ff;
      ctr_new  = ctr;
      if (s1_taken_ff) begin
         if (ctr < ctr_top) begin
            ctr_new = ctr + 1'b1;
         end
      end else if (ctr != '0) begin
         ctr_new = ctr - 1'b1;
      end
   end

   cbp_table #(
      .INDEX_BITS(INDEX_BITS),
      .CTR_W     (CTR_W)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_idx (idx_in),
      .rd_data(rd_data),
      .wr_en  (s1_go),
      .wr_idx (s1_idx_ff),
      .wr_data(ctr_new),
      .busy   (tbl_busy)
   );

   assign stat_step = '{step: s1_go, taken: s1_taken_ff, right: right};

   cbp_stats u_stats (
      .clock   (clock),
      .reset   (reset),
      .step    (stat_step),
      .branches(rsp_bus.branches_seen),
      .takens  (rsp_bus.taken_seen),
      .corrects(rsp_bus.correct_seen)
   );

   // output register
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         pred_ff  <= pred;
         right_ff <= right;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.predicted_taken    = pred_ff;
   assign rsp_bus.prediction_correct = right_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      tbl_busy |-> !accept) else $error("beat accepted during table clear");

   a_go_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_bus.valid) else $error("update stage advanced without response");

   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      accept |=> hist_ff[0] == $past(req_bus.branch_taken))
      else $error("history did not take the outcome");

   a_stage_free: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || s1_go)) else $error("update stage overrun");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (s1_go && rsp_bus.branches_seen != '1)
      |=> rsp_bus.branches_seen == $past(rsp_bus.branches_seen) + 32'd1)
      else $error("branch count did not advance");

endmodule
